### rtl/core/ipv4_tcp_checksum_recompute_unit_macros.svh
// ----------------------------------------------------------------------------
// IPv4/TCP checksum recompute unit - assertion macros
// Shared helpers for the concurrent checks; clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_TCP_CHECKSUM_RECOMPUTE_UNIT_MACROS_SVH
`define IPV4_TCP_CHECKSUM_RECOMPUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define ITCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ITCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/itcr_pkg.sv
// ----------------------------------------------------------------------------
// itcr_pkg
// Beat types, offsets and one's-complement helpers for the checksum unit.
// ----------------------------------------------------------------------------
package itcr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
        logic        short_packet;
    } out_beat_t;

    // Packet summary handed from the accumulator to the fold stage.
    typedef struct packed {
        logic [31:0] ip_sum;
        logic [31:0] tcp_sum;
        logic [15:0] seg_length;
        logic        short_packet;
    } finish_t;

    localparam logic [3:0]  HDR_LEN_MASK    = 4'hf;
    localparam logic [15:0] OFS_LEN_HI      = 16'd2;
    localparam logic [15:0] OFS_LEN_LO      = 16'd3;
    localparam logic [15:0] OFS_LEN_END     = 16'd4;
    localparam logic [15:0] OFS_IP_CSUM_HI  = 16'd10;
    localparam logic [15:0] OFS_IP_CSUM_LO  = 16'd11;
    localparam logic [15:0] OFS_ADDR_FIRST  = 16'd12;
    localparam logic [15:0] OFS_ADDR_END    = 16'd20;
    localparam logic [6:0]  TCP_CSUM_OFS_HI = 7'd16;
    localparam logic [6:0]  TCP_CSUM_OFS_LO = 7'd17;
    localparam logic [15:0] OFS_SATURATE    = 16'hffff;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;

    // 32-bit one's-complement add with end-around carry.
    function automatic logic [31:0] oc_add(input logic [31:0] s, input logic [31:0] a);
        logic [32:0] t;
        t = {1'b0, s} + {1'b0, a};
        return t[31:0] + {31'b0, t[32]};
    endfunction

endpackage

### rtl/core/ipv4_tcp_checksum_recompute_unit.sv
// ----------------------------------------------------------------------------
// ipv4_tcp_checksum_recompute_unit
// Path: a result's last byte goes from stage A through stage F to the m_data register.
// Throughput: one packet byte per cycle, unless a last beat waits on a full stage F.
// Reset: synchronous active-low aresetn clears all valids and packet state.
// Recomputes the IPv4 header checksum and the TCP checksum (with the
// pseudo-header) over a byte stream; one result per packet on the last beat.
// ----------------------------------------------------------------------------
`include "ipv4_tcp_checksum_recompute_unit_macros.svh"

module ipv4_tcp_checksum_recompute_unit import itcr_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // Stage A: input register for one beat.
    logic      a_valid_reg, a_valid_next;
    in_beat_t  a_beat_reg, a_beat_next;
    // Stage F: packet summary waiting for the fold.
    logic      f_valid_reg, f_valid_next;
    finish_t   f_data_reg, f_data_next;
    // Output register.
    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;

    logic      out_free;
    logic      f_free;
    logic      a_consume;
    logic      f_move;
    finish_t   fin;
    out_beat_t folded;

    // A beat that is not last always drains into the running sums; only a
    // last beat needs room in the summary stage. Ready therefore drops only
    // when a last beat is stuck behind a full summary and output register.
    assign out_free  = !m_valid_reg || m_ready;
    assign f_free    = !f_valid_reg || out_free;
    assign a_consume = a_valid_reg && (!a_beat_reg.last_byte || f_free);
    assign f_move    = f_valid_reg && out_free;
    assign s_ready   = !a_valid_reg || a_consume;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    itcr_accum #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_valid(a_consume),
        .beat      (a_beat_reg),
        .fin       (fin)
    );

    itcr_fold u_fold (
        .fin(f_data_reg),
        .res(folded)
    );

    always_comb begin
        a_valid_next = a_valid_reg;
        a_beat_next = a_beat_reg;
        // Take a new beat whenever the held one leaves or the slot is empty.
        if (s_valid && s_ready) begin
            a_valid_next = 1'b1;
            a_beat_next = s_data;
        end else if (a_consume) begin
            a_valid_next = 1'b0;
        end

        f_valid_next = f_valid_reg;
        f_data_next = f_data_reg;
        // Load the summary on a last beat, otherwise empty it once it advances.
        if (a_consume && a_beat_reg.last_byte) begin
            f_valid_next = 1'b1;
            f_data_next = fin;
        end else if (f_move) begin
            f_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        // Hold the result until taken; refill in the same cycle it drains.
        if (f_move) begin
            m_valid_next = 1'b1;
            m_data_next = folded;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            f_valid_reg <= f_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        a_beat_reg <= a_beat_next;
        f_data_reg <= f_data_next;
        m_data_reg <= m_data_next;
    end

    `ITCR_ASSERT_NEXT(a_last_loads_summary, a_consume && a_beat_reg.last_byte, f_valid_reg, "last beat consumed without a summary")
    `ITCR_ASSERT_NEXT(a_summary_holds, f_valid_reg && !out_free, f_valid_reg && $stable(f_data_reg), "summary lost while output stalled")
    `ITCR_ASSERT_NOW(a_blocked_last_stalls, a_valid_reg && a_beat_reg.last_byte && !f_free, !s_ready, "input taken over a blocked last beat")
    `ITCR_ASSERT_NOW(a_plain_beat_drains, a_valid_reg && !a_beat_reg.last_byte, a_consume && s_ready, "non-last beat failed to drain")

endmodule

### rtl/core/itcr_accum.sv
// ----------------------------------------------------------------------------
// itcr_accum
// Per-byte header parse and running IP/TCP sums; summary out on the last beat.
// ----------------------------------------------------------------------------
module itcr_accum import itcr_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     beat_valid,
    input  in_beat_t beat,
    output finish_t  fin
);

    localparam logic [15:0] MAX_LEN = MAX_PACKET_BYTES[15:0];

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [5:0]  header_bytes_reg, header_bytes_next;
    logic [15:0] packet_length_reg, packet_length_next;
    logic [31:0] ip_sum_reg, ip_sum_next;
    logic [31:0] tcp_sum_reg, tcp_sum_next;

    logic [15:0] ofs;
    logic [5:0]  hb_cur;
    logic [15:0] pl_cur;
    logic [15:0] eff_len;
    logic        counted;
    logic [15:0] weighted;
    logic        in_hdr;
    logic [6:0]  tcp_ck_hi;
    logic [6:0]  tcp_ck_lo;
    logic        tcp_region;
    logic        addr_byte;
    logic        ip_take;
    logic [16:0] tcp_add;
    logic [31:0] ip_sum_upd;
    logic [31:0] tcp_sum_upd;
    logic [16:0] got;

    always_comb begin
        ofs = byte_offset_reg;
        hb_cur = (ofs == '0) ? {beat.data_byte[3:0] & HDR_LEN_MASK, 2'b00}
                             : header_bytes_reg;
        pl_cur = packet_length_reg;
        if (ofs == OFS_LEN_HI) begin
            pl_cur = {beat.data_byte, packet_length_reg[7:0]};
        end else if (ofs == OFS_LEN_LO) begin
            pl_cur = {packet_length_reg[15:8], beat.data_byte};
        end
        eff_len = (pl_cur < MAX_LEN) ? pl_cur : MAX_LEN;
        counted = (ofs < OFS_LEN_END) || (ofs < eff_len);
        weighted = ofs[0] ? {8'h00, beat.data_byte} : {beat.data_byte, 8'h00};

        in_hdr = ofs < {10'b0, hb_cur};
        tcp_ck_hi = {1'b0, hb_cur} + TCP_CSUM_OFS_HI;
        tcp_ck_lo = {1'b0, hb_cur} + TCP_CSUM_OFS_LO;
        ip_take = counted && in_hdr && (ofs != OFS_IP_CSUM_HI) && (ofs != OFS_IP_CSUM_LO);
        tcp_region = counted && !in_hdr && (ofs != {9'b0, tcp_ck_hi})
                     && (ofs != {9'b0, tcp_ck_lo});
        addr_byte = counted && (ofs >= OFS_ADDR_FIRST) && (ofs < OFS_ADDR_END);

        // Address bytes may land in both the segment and the pseudo-header.
        tcp_add = (tcp_region ? {1'b0, weighted} : 17'd0)
                + (addr_byte ? {1'b0, weighted} : 17'd0);
        ip_sum_upd = ip_take ? oc_add(ip_sum_reg, {16'b0, weighted}) : ip_sum_reg;
        tcp_sum_upd = (tcp_add != '0) ? oc_add(tcp_sum_reg, {15'b0, tcp_add}) : tcp_sum_reg;

        got = {1'b0, ofs} + 17'd1;
        fin.ip_sum = ip_sum_upd;
        fin.tcp_sum = tcp_sum_upd;
        fin.seg_length = (eff_len > {10'b0, hb_cur}) ? (eff_len - {10'b0, hb_cur}) : 16'd0;
        fin.short_packet = (got < {1'b0, OFS_LEN_END}) || (got < {11'b0, hb_cur})
                           || (got < {1'b0, eff_len});
    end

    always_comb begin
        byte_offset_next = byte_offset_reg;
        header_bytes_next = header_bytes_reg;
        packet_length_next = packet_length_reg;
        ip_sum_next = ip_sum_reg;
        tcp_sum_next = tcp_sum_reg;
        if (beat_valid) begin
            if (beat.last_byte) begin
                // Drop all packet state for the next packet.
                byte_offset_next = '0;
                header_bytes_next = '0;
                packet_length_next = '0;
                ip_sum_next = '0;
                tcp_sum_next = '0;
            end else begin
                byte_offset_next = (ofs != OFS_SATURATE) ? ofs + 16'd1 : ofs;
                header_bytes_next = hb_cur;
                packet_length_next = pl_cur;
                ip_sum_next = ip_sum_upd;
                tcp_sum_next = tcp_sum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= '0;
            header_bytes_reg <= '0;
            packet_length_reg <= '0;
            ip_sum_reg <= '0;
            tcp_sum_reg <= '0;
        end else begin
            byte_offset_reg <= byte_offset_next;
            header_bytes_reg <= header_bytes_next;
            packet_length_reg <= packet_length_next;
            ip_sum_reg <= ip_sum_next;
            tcp_sum_reg <= tcp_sum_next;
        end
    end

endmodule

### rtl/core/itcr_fold.sv
// ----------------------------------------------------------------------------
// itcr_fold
// Adds the pseudo-header protocol and length terms, folds to 16 bits, inverts.
// ----------------------------------------------------------------------------
module itcr_fold import itcr_pkg::*; (
    input  finish_t   fin,
    output out_beat_t res
);

    // Fold a 34-bit sum to 16 bits; a nonzero input never folds to zero.
    function automatic logic [15:0] fold16(input logic [33:0] s);
        logic [17:0] y;
        logic [16:0] z;
        y = {2'b0, s[15:0]} + {2'b0, s[31:16]} + {16'b0, s[33:32]};
        z = {1'b0, y[15:0]} + {15'b0, y[17:16]};
        return z[15:0] + {15'b0, z[16]};
    endfunction

    logic [33:0] tcp_total;

    always_comb begin
        tcp_total = {2'b0, fin.tcp_sum} + {18'b0, fin.seg_length} + {26'b0, PROTO_TCP};
        res.ip_checksum = ~fold16({2'b0, fin.ip_sum});
        res.tcp_checksum = ~fold16(tcp_total);
        res.short_packet = fin.short_packet;
    end

endmodule
